FILE: design/pts_pkg.sv
// ============================================================================
// pts_pkg
// Shared constants and types for the priority task scheduler.
// ============================================================================
package pts_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int PRIO_W         = 8;

    // slot status codes
    localparam logic [1:0] ST_UNUSED  = 2'd0;
    localparam logic [1:0] ST_READY   = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_DEAD    = 2'd3;

    // event kinds
    localparam logic [1:0] MODE_CREATE = 2'd0;
    localparam logic [1:0] MODE_START  = 2'd1;
    localparam logic [1:0] MODE_YIELD  = 2'd2;
    localparam logic [1:0] MODE_EXIT   = 2'd3;

    // result status codes
    localparam logic [1:0] RES_OK      = 2'd0;
    localparam logic [1:0] RES_REFUSED = 2'd1;
    localparam logic [1:0] RES_IGNORED = 2'd2;
    localparam logic [1:0] RES_NO_TASK = 2'd3;

    // status write broadcast to all cells
    typedef struct packed {
        logic       en;
        logic       keep_dead;  // leave a dead slot dead
        logic [1:0] val;
    } t_stat_wr;

endpackage

FILE: design/priority_task_scheduler.sv
// ============================================================================
// priority_task_scheduler
// Fixed-priority cooperative task table built as a row of slot cells.
// ============================================================================
//  channel  valid    ready    payload
//  event    i_valid  o_ready  i_mode, i_priority_req, i_has_entry
//  result   o_valid  i_ready  o_task_index, o_status, o_tasks_in_table
//
//  Create and events that are ignored go from accept to result without a
//  scan. Start, yield and exit send a scan item down the row of cells,
//  and each cell registers the item before passing it on.
//  One event is in work at a time; the next is taken once the result sits
//  in the output register, even if it is not yet taken.
//  Reset empties the table and stops the scheduler.
// ============================================================================
module priority_task_scheduler import pts_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    parameter int IDX_W      = $clog2(TASK_SLOTS),
    parameter int CNT_W      = $clog2(TASK_SLOTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [PRIO_W-1:0] i_priority_req,
    input  logic              i_has_entry,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [IDX_W-1:0]  o_task_index,
    output logic [1:0]        o_status,
    output logic [CNT_W-1:0]  o_tasks_in_table
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [1:0]       r_mode, n_mode;
    logic [CNT_W-1:0] r_total, n_total;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic             r_cv, n_cv;
    logic             r_on, n_on;
    logic             r_launch, n_launch;
    logic [IDX_W-1:0] r_res_idx, n_res_idx;
    logic [1:0]       r_res_st, n_res_st;
    logic             r_o_valid;
    logic [IDX_W-1:0] r_o_idx;
    logic [1:0]       r_o_st;
    logic [CNT_W-1:0] r_o_cnt;

    t_stat_wr         wr_a, wr_b;
    logic [IDX_W-1:0] idx_a, idx_b;
    logic             prio_we;
    logic             accept, out_load;

    logic              tok_vld   [TASK_SLOTS+1];
    logic              tok_found [TASK_SLOTS+1];
    logic [PRIO_W-1:0] tok_prio  [TASK_SLOTS+1];
    logic [IDX_W-1:0]  tok_idx   [TASK_SLOTS+1];

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_load = (r_state == S_DONE) && (!r_o_valid || i_ready);

    assign tok_vld[0]   = r_launch;
    assign tok_found[0] = 1'b0;
    assign tok_prio[0]  = '0;
    assign tok_idx[0]   = '0;

    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        pts_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_a      (wr_a),
            .i_idx_a     (idx_a),
            .i_prio_we   (prio_we),
            .i_prio      (i_priority_req),
            .i_wr_b      (wr_b),
            .i_idx_b     (idx_b),
            .i_tok_vld   (tok_vld[g]),
            .i_tok_found (tok_found[g]),
            .i_tok_prio  (tok_prio[g]),
            .i_tok_idx   (tok_idx[g]),
            .o_tok_vld   (tok_vld[g+1]),
            .o_tok_found (tok_found[g+1]),
            .o_tok_prio  (tok_prio[g+1]),
            .o_tok_idx   (tok_idx[g+1])
        );
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_total   = r_total;
        n_cur     = r_cur;
        n_cv      = r_cv;
        n_on      = r_on;
        n_launch  = 1'b0;
        n_res_idx = r_res_idx;
        n_res_st  = r_res_st;
        wr_a      = '{en: 1'b0, keep_dead: 1'b0, val: ST_UNUSED};
        wr_b      = '{en: 1'b0, keep_dead: 1'b0, val: ST_UNUSED};
        idx_a     = r_cur;
        idx_b     = tok_idx[TASK_SLOTS];
        prio_we   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode    = i_mode;
                    n_res_idx = '0;
                    n_res_st  = RES_OK;
                    n_state   = S_DONE;
                    unique case (i_mode)
                        MODE_CREATE: begin
                            if (r_total >= CNT_W'(TASK_SLOTS) || !i_has_entry) begin
                                n_res_st = RES_REFUSED;
                            end else begin
                                idx_a     = r_total[IDX_W-1:0];
                                wr_a      = '{en: 1'b1, keep_dead: 1'b0, val: ST_READY};
                                prio_we   = 1'b1;
                                n_res_idx = r_total[IDX_W-1:0];
                                n_total   = r_total + 1'b1;
                            end
                        end
                        MODE_START: begin
                            if (r_on && r_cv) begin
                                n_res_st = RES_IGNORED;
                            end else begin
                                n_on     = 1'b1;
                                n_launch = 1'b1;
                                n_state  = S_SCAN;
                            end
                        end
                        MODE_YIELD: begin
                            if (!r_on || !r_cv) begin
                                n_res_st = RES_IGNORED;
                            end else begin
                                n_launch = 1'b1;
                                n_state  = S_SCAN;
                            end
                        end
                        MODE_EXIT: begin
                            if (!r_cv) begin
                                n_res_st = RES_IGNORED;
                            end else begin
                                // mark dead before the scan sees the slot
                                wr_a = '{en: 1'b1, keep_dead: 1'b0, val: ST_DEAD};
                                if (!r_on) begin
                                    n_res_st = RES_IGNORED;
                                end else begin
                                    n_launch = 1'b1;
                                    n_state  = S_SCAN;
                                end
                            end
                        end
                        default: n_res_st = RES_IGNORED;
                    endcase
                end
            end
            S_SCAN: begin
                if (tok_vld[TASK_SLOTS]) begin
                    n_state = S_DONE;
                    if (!tok_found[TASK_SLOTS]) begin
                        n_res_st = RES_NO_TASK;
                        if (r_mode != MODE_START) begin
                            n_on = 1'b0;
                        end
                    end else begin
                        wr_b      = '{en: 1'b1, keep_dead: 1'b0, val: ST_RUNNING};
                        n_cur     = tok_idx[TASK_SLOTS];
                        n_cv      = 1'b1;
                        n_res_idx = tok_idx[TASK_SLOTS];
                        if (r_mode != MODE_START) begin
                            // hand the old task back unless it exited
                            wr_a = '{en: 1'b1, keep_dead: 1'b1, val: ST_READY};
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_cur     <= '0;
            r_cv      <= 1'b0;
            r_on      <= 1'b0;
            r_launch  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_total  <= n_total;
            r_cur    <= n_cur;
            r_cv     <= n_cv;
            r_on     <= n_on;
            r_launch <= n_launch;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode    <= n_mode;
        r_res_idx <= n_res_idx;
        r_res_st  <= n_res_st;
        if (out_load) begin
            r_o_idx <= r_res_idx;
            r_o_st  <= r_res_st;
            r_o_cnt <= r_total;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_task_index     = r_o_idx;
    assign o_status         = r_o_st;
    assign o_tasks_in_table = r_o_cnt;

endmodule

FILE: design/pts_cell.sv
// ============================================================================
// pts_cell
// One task slot: holds priority and status, and passes the scan item on,
// replacing the best candidate when this slot is ready and not lower.
// ============================================================================
module pts_cell import pts_pkg::*; #(
    parameter int IDX_W    = 3,
    parameter int CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_stat_wr          i_wr_a,
    input  logic [IDX_W-1:0]  i_idx_a,
    input  logic              i_prio_we,
    input  logic [PRIO_W-1:0] i_prio,
    input  t_stat_wr          i_wr_b,
    input  logic [IDX_W-1:0]  i_idx_b,
    input  logic              i_tok_vld,
    input  logic              i_tok_found,
    input  logic [PRIO_W-1:0] i_tok_prio,
    input  logic [IDX_W-1:0]  i_tok_idx,
    output logic              o_tok_vld,
    output logic              o_tok_found,
    output logic [PRIO_W-1:0] o_tok_prio,
    output logic [IDX_W-1:0]  o_tok_idx
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [1:0]        r_stat, n_stat;
    logic [PRIO_W-1:0] r_prio;
    logic              r_tok_vld, r_tok_found;
    logic [PRIO_W-1:0] r_tok_prio;
    logic [IDX_W-1:0]  r_tok_idx;
    logic              take;
    logic              hit_a, hit_b;

    assign hit_a = i_wr_a.en && (i_idx_a == MY_IDX);
    assign hit_b = i_wr_b.en && (i_idx_b == MY_IDX);

    always_comb begin
        n_stat = r_stat;
        if (hit_a && !(i_wr_a.keep_dead && r_stat == ST_DEAD)) begin
            n_stat = i_wr_a.val;
        end
        if (hit_b && !(i_wr_b.keep_dead && r_stat == ST_DEAD)) begin
            n_stat = i_wr_b.val;
        end
    end

    // tie goes to the later slot
    assign take = (r_stat == ST_READY) && (r_prio >= i_tok_prio);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stat    <= ST_UNUSED;
            r_tok_vld <= 1'b0;
        end else begin
            r_stat    <= n_stat;
            r_tok_vld <= i_tok_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_prio_we && hit_a) begin
            r_prio <= i_prio;
        end
        r_tok_found <= i_tok_found | take;
        r_tok_prio  <= take ? r_prio : i_tok_prio;
        r_tok_idx   <= take ? MY_IDX : i_tok_idx;
    end

    assign o_tok_vld   = r_tok_vld;
    assign o_tok_found = r_tok_found;
    assign o_tok_prio  = r_tok_prio;
    assign o_tok_idx   = r_tok_idx;

endmodule

FILE: design/pts_checker.sv
// ============================================================================
// pts_checker
// Port-level checks on the priority task scheduler.
// ============================================================================
module pts_checker import pts_pkg::*; #(
    parameter int TASK_SLOTS = TASK_SLOTS_DEF,
    parameter int IDX_W      = $clog2(TASK_SLOTS),
    parameter int CNT_W      = $clog2(TASK_SLOTS + 1)
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [IDX_W-1:0]  o_task_index,
    input logic [1:0]        o_status,
    input logic [CNT_W-1:0]  o_tasks_in_table
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && o_valid && !i_ready |=>
            o_valid && $stable(o_task_index) && $stable(o_status)
            && $stable(o_tasks_in_table))
        else $error("result changed while stalled");

    // one event at a time
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("event taken while another is in work");

    a_idx_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == RES_OK |->
            CNT_W'(o_task_index) < o_tasks_in_table)
        else $error("task index beyond created tasks");

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != RES_OK |-> o_task_index == '0)
        else $error("task index not zero on failed event");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_tasks_in_table <= CNT_W'(TASK_SLOTS))
        else $error("task count beyond table size");

endmodule

bind priority_task_scheduler pts_checker #(
    .TASK_SLOTS (TASK_SLOTS)
) u_pts_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_task_index     (o_task_index),
    .o_status         (o_status),
    .o_tasks_in_table (o_tasks_in_table)
);
